>>> hw/rtl/sem_pkg.sv
// Shared types and constants for the Sobel edge magnitude core.
`timescale 1ns / 1ps

package sem_pkg;

    localparam int PIXEL_W      = 8;
    localparam int ROW_W        = 12;
    localparam int COL_W        = 10;
    localparam int FRAME_W_W    = 11;
    localparam int FRAME_H_W    = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_INDEX_W  = 1;
    localparam int GRAD_W       = 10;
    localparam int SQUARE_W     = 2 * GRAD_W;
    localparam int ROOT_W       = 8;

    localparam int MAX_WIDTH_DEFAULT = 1024;
    localparam int MAX_HEIGHT        = 4096;
    localparam int FRAME_W_RESET     = 640;
    localparam int FRAME_H_RESET     = 480;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SQUARE,
        ST_SUM,
        ST_ROOT,
        ST_DONE
    } state_t;

endpackage

>>> hw/rtl/sobel_edge_magnitude_core.sv
// Sobel edge magnitude core: line store memory, 3x3 window and square root unit.
`timescale 1ns / 1ps

// Pixels enter one word at a time in raster order; one result word leaves for each
// interior pixel, tagged with its row, column and a flag on the frame's last one.
// Both line stores share one 16-bit memory with a registered read: a word is read
// as it is accepted and written back in READ, which also shifts the window, and a
// border pixel then frees the core. An interior pixel adds a squaring state, a
// summing state and the bit-per-cycle square root, 8 iterations, then waits in
// DONE; the root is skipped when the magnitude saturates at 255. A held result
// does not block the next pixel; it only stalls the core when the next result is
// ready. Writing either size register restarts the frame at row 0, column 0.
module sobel_edge_magnitude_core #(
    parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [sem_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                pixel_valid,
    output logic                                pixel_ready,
    input  logic [sem_pkg::PIXEL_W-1:0]         pixel,
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic [sem_pkg::PIXEL_W-1:0]         magnitude,
    output logic [sem_pkg::ROW_W-1:0]           out_row,
    output logic [sem_pkg::COL_W-1:0]           out_col,
    output logic                                frame_last
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int EW = (WW > sem_pkg::FRAME_W_W) ? WW : sem_pkg::FRAME_W_W;
    localparam int HW = sem_pkg::FRAME_H_W;
    localparam int PW = sem_pkg::PIXEL_W;
    localparam int GW = sem_pkg::GRAD_W;
    localparam int SW = sem_pkg::SQUARE_W;
    localparam int RW = sem_pkg::ROOT_W;

    sem_pkg::state_t state_reg;
    sem_pkg::state_t state_next;

    logic [sem_pkg::FRAME_W_W-1:0] frame_width_reg;
    logic [HW-1:0]                 frame_height_reg;
    logic [CW-1:0]                 col_count_reg;
    logic [sem_pkg::ROW_W-1:0]     row_count_reg;

    logic [EW-1:0] width_ext;
    logic [EW-1:0] eff_w;
    logic [HW-1:0] eff_h;
    logic [EW-1:0] col_ext;
    logic [EW-1:0] col_plus;
    logic [HW-1:0] row_ext;
    logic [HW-1:0] row_plus;

    logic [2*PW-1:0] mem [MAX_WIDTH];
    logic [2*PW-1:0] rd_data_reg;
    logic            mem_wr_en;
    logic            accept;

    logic [PW-1:0]             px_reg;
    logic [CW-1:0]             addr_reg;
    logic                      emit_reg;
    logic                      last_reg;
    logic [sem_pkg::ROW_W-1:0] item_row_reg;
    logic [sem_pkg::COL_W-1:0] item_col_reg;
    logic [PW-1:0]             win_reg [6];

    logic [PW-1:0] top_px;
    logic [PW-1:0] mid_px;
    logic [GW-1:0] pos_x;
    logic [GW-1:0] neg_x;
    logic [GW-1:0] pos_y;
    logic [GW-1:0] neg_y;
    logic [GW:0]   diff_x;
    logic [GW:0]   diff_y;
    logic [GW:0]   abs_x;
    logic [GW:0]   abs_y;

    logic [GW-1:0] ux_reg;
    logic [GW-1:0] uy_reg;
    logic [SW-1:0] sqx_reg;
    logic [SW-1:0] sqy_reg;
    logic [SW:0]   sum_sq;
    logic          sum_big;
    logic [2*RW-1:0] v_reg;
    logic [RW-1:0] root_reg;
    logic [RW-1:0] bit_reg;
    logic [RW-1:0] trial;
    logic [2*RW-1:0] trial_sq;

    logic result_valid_reg;
    logic out_free;
    logic out_load;

    logic [PW-1:0]             magnitude_reg;
    logic [sem_pkg::ROW_W-1:0] out_row_reg;
    logic [sem_pkg::COL_W-1:0] out_col_reg;
    logic                      frame_last_reg;

    // Effective frame size, saturated to the supported range.
    always_comb
    begin
        width_ext = EW'(frame_width_reg);
        if (width_ext < EW'(3))
        begin
            eff_w = EW'(3);
        end
        else if (width_ext > EW'(MAX_WIDTH))
        begin
            eff_w = EW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = width_ext;
        end
        if (frame_height_reg < HW'(3))
        begin
            eff_h = HW'(3);
        end
        else if (frame_height_reg > HW'(sem_pkg::MAX_HEIGHT))
        begin
            eff_h = HW'(sem_pkg::MAX_HEIGHT);
        end
        else
        begin
            eff_h = frame_height_reg;
        end
        col_ext  = EW'(col_count_reg);
        col_plus = col_ext + EW'(1);
        row_ext  = HW'(row_count_reg);
        row_plus = row_ext + HW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= sem_pkg::FRAME_W_W'(sem_pkg::FRAME_W_RESET);
            frame_height_reg <= HW'(sem_pkg::FRAME_H_RESET);
            col_count_reg    <= '0;
            row_count_reg    <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                sem_pkg::CFG_FRAME_WIDTH:
                    frame_width_reg <= cfg_data[sem_pkg::FRAME_W_W-1:0];
                sem_pkg::CFG_FRAME_HEIGHT:
                    frame_height_reg <= cfg_data[HW-1:0];
                default:
                    frame_width_reg <= frame_width_reg;
            endcase
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else if (accept)
        begin
            if (col_plus >= eff_w)
            begin
                col_count_reg <= '0;
                if (row_plus >= eff_h)
                begin
                    row_count_reg <= '0;
                end
                else
                begin
                    row_count_reg <= row_plus[sem_pkg::ROW_W-1:0];
                end
            end
            else
            begin
                col_count_reg <= col_plus[CW-1:0];
            end
        end
    end

    // Line store memory: each entry holds {row two above, row above}.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= mem[col_count_reg];
        end
        if (mem_wr_en)
        begin
            mem[addr_reg] <= {rd_data_reg[PW-1:0], px_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg       <= pixel;
            addr_reg     <= col_count_reg;
            emit_reg     <= (row_count_reg >= sem_pkg::ROW_W'(2)) && (col_ext >= EW'(2));
            last_reg     <= (row_ext == eff_h - HW'(1)) && (col_ext == eff_w - EW'(1));
            item_row_reg <= row_count_reg - sem_pkg::ROW_W'(1);
            item_col_reg <= sem_pkg::COL_W'(col_ext - EW'(1));
        end
    end

    assign top_px = rd_data_reg[2*PW-1:PW];
    assign mid_px = rd_data_reg[PW-1:0];

    always_comb
    begin
        pos_x  = GW'(top_px) + (GW'(mid_px) << 1) + GW'(px_reg);
        neg_x  = GW'(win_reg[0]) + (GW'(win_reg[2]) << 1) + GW'(win_reg[4]);
        pos_y  = GW'(win_reg[4]) + (GW'(win_reg[5]) << 1) + GW'(px_reg);
        neg_y  = GW'(win_reg[0]) + (GW'(win_reg[1]) << 1) + GW'(top_px);
        diff_x = {1'b0, pos_x} - {1'b0, neg_x};
        diff_y = {1'b0, pos_y} - {1'b0, neg_y};
        abs_x  = diff_x[GW] ? (~diff_x + (GW+1)'(1)) : diff_x;
        abs_y  = diff_y[GW] ? (~diff_y + (GW+1)'(1)) : diff_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (mem_wr_en)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= top_px;
            win_reg[2] <= win_reg[3];
            win_reg[3] <= mid_px;
            win_reg[4] <= win_reg[5];
            win_reg[5] <= px_reg;
        end
    end

    assign sum_sq   = (SW+1)'(sqx_reg) + (SW+1)'(sqy_reg);
    assign sum_big  = |sum_sq[SW:2*RW];
    assign trial    = root_reg | bit_reg;
    assign trial_sq = (2*RW)'(trial) * (2*RW)'(trial);

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            sem_pkg::ST_READ:
            begin
                ux_reg <= abs_x[GW-1:0];
                uy_reg <= abs_y[GW-1:0];
            end
            sem_pkg::ST_SQUARE:
            begin
                sqx_reg <= SW'(ux_reg) * SW'(ux_reg);
                sqy_reg <= SW'(uy_reg) * SW'(uy_reg);
            end
            sem_pkg::ST_SUM:
            begin
                v_reg    <= sum_sq[2*RW-1:0];
                root_reg <= sum_big ? {RW{1'b1}} : '0;
                bit_reg  <= {1'b1, {(RW-1){1'b0}}};
            end
            sem_pkg::ST_ROOT:
            begin
                if (trial_sq <= v_reg)
                begin
                    root_reg <= trial;
                end
                bit_reg <= bit_reg >> 1;
            end
            default:
            begin
                bit_reg <= bit_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sem_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sem_pkg::ST_IDLE:
                if (pixel_valid)
                begin
                    state_next = sem_pkg::ST_READ;
                end
            sem_pkg::ST_READ:
                state_next = emit_reg ? sem_pkg::ST_SQUARE : sem_pkg::ST_IDLE;
            sem_pkg::ST_SQUARE:
                state_next = sem_pkg::ST_SUM;
            sem_pkg::ST_SUM:
                state_next = sum_big ? sem_pkg::ST_DONE : sem_pkg::ST_ROOT;
            sem_pkg::ST_ROOT:
                if (bit_reg[0])
                begin
                    state_next = sem_pkg::ST_DONE;
                end
            sem_pkg::ST_DONE:
                if (out_free)
                begin
                    state_next = sem_pkg::ST_IDLE;
                end
            default:
                state_next = sem_pkg::ST_IDLE;
        endcase
    end

    assign out_free = !result_valid_reg || result_ready;

    always_comb
    begin
        pixel_ready = 1'b0;
        mem_wr_en   = 1'b0;
        out_load    = 1'b0;
        unique case (state_reg)
            sem_pkg::ST_IDLE:
                pixel_ready = 1'b1;
            sem_pkg::ST_READ:
                mem_wr_en = 1'b1;
            sem_pkg::ST_DONE:
                out_load = out_free;
            default:
                out_load = 1'b0;
        endcase
    end

    assign accept = pixel_valid && pixel_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            magnitude_reg  <= root_reg;
            out_row_reg    <= item_row_reg;
            out_col_reg    <= item_col_reg;
            frame_last_reg <= last_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign magnitude    = magnitude_reg;
    assign out_row      = out_row_reg;
    assign out_col      = out_col_reg;
    assign frame_last   = frame_last_reg;

    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == sem_pkg::ST_READ)
        else $error("Accepted word did not move to the read cycle.");

    a_root_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sem_pkg::ST_ROOT |-> $onehot(bit_reg))
        else $error("Square root trial bit is not one-hot.");

    a_load_emits: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> emit_reg)
        else $error("Result loaded for a border pixel.");

    a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        col_ext < eff_w)
        else $error("Column counter beyond the frame width.");

    a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        row_ext < eff_h)
        else $error("Row counter beyond the frame height.");

endmodule

>>> test/sobel_edge_magnitude_core_test.sv
// Self-checking testbench for the Sobel edge magnitude core with a predictor and random stalls.
`timescale 1ns / 1ps

module sobel_edge_magnitude_core_test;

    localparam int LINE_DEPTH    = sem_pkg::MAX_WIDTH_DEFAULT;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 300;
    localparam int HOLD_AFTER    = 200;
    localparam int RANDOM_PIXELS = 1050;
    localparam int IDLE_PCT      = 25;

    typedef enum int {
        TEX_RANDOM,
        TEX_BINARY,
        TEX_FLAT
    } texture_t;

    typedef struct packed {
        logic [sem_pkg::PIXEL_W-1:0] magnitude;
        logic [sem_pkg::ROW_W-1:0]   row;
        logic [sem_pkg::COL_W-1:0]   col;
        logic                        last;
    } sobel_word_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [sem_pkg::CFG_INDEX_W-1:0] cfg_index = sem_pkg::CFG_FRAME_WIDTH;
    logic [sem_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    logic                            pixel_valid = 1'b0;
    logic                            pixel_ready;
    logic [sem_pkg::PIXEL_W-1:0]     pixel = '0;
    logic                            result_valid;
    logic                            result_ready = 1'b0;
    logic [sem_pkg::PIXEL_W-1:0]     magnitude;
    logic [sem_pkg::ROW_W-1:0]       out_row;
    logic [sem_pkg::COL_W-1:0]       out_col;
    logic                            frame_last;

    logic [sem_pkg::FRAME_W_W-1:0] width_reg =
        sem_pkg::FRAME_W_W'(sem_pkg::FRAME_W_RESET);
    logic [sem_pkg::FRAME_H_W-1:0] height_reg =
        sem_pkg::FRAME_H_W'(sem_pkg::FRAME_H_RESET);
    logic [sem_pkg::PIXEL_W-1:0]   row_above [LINE_DEPTH];
    logic [sem_pkg::PIXEL_W-1:0]   row_two_above [LINE_DEPTH];
    int                            window [6];
    int                            col_pos = 0;
    int                            row_pos = 0;

    logic [sem_pkg::PIXEL_W-1:0] pixel_queue [$];
    sobel_word_t                 gradient_queue [$];
    sobel_word_t                 head;
    logic                        pixel_taken_now = 1'b0;
    int                          pixels_taken = 0;
    int                          idle_pct = IDLE_PCT;
    int                          failures = 0;
    bit                          hold_started = 1'b0;
    int                          hold_left = 0;

    sobel_edge_magnitude_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .magnitude    (magnitude),
        .out_row      (out_row),
        .out_col      (out_col),
        .frame_last   (frame_last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int clamp_size(input int value, input int upper);
        if (value < 3)
        begin
            return 3;
        end
        return (value > upper) ? upper : value;
    endfunction

    function automatic logic [sem_pkg::PIXEL_W-1:0] floor_root(input int value);
        int k;
        if (value >= 65536)
        begin
            return 8'd255;
        end
        k = 0;
        while ((k + 1) * (k + 1) <= value)
        begin
            k++;
        end
        return k[sem_pkg::PIXEL_W-1:0];
    endfunction

    // The window holds columns c-2 and c-1 of the top, middle and bottom rows in pairs.
    task automatic compute_gradient(input logic [sem_pkg::PIXEL_W-1:0] px);
        int w;
        int h;
        int c;
        int top_px;
        int mid_px;
        int bot_px;
        int sx;
        int sy;
        sobel_word_t word;
        w = clamp_size(int'(width_reg), LINE_DEPTH);
        h = clamp_size(int'(height_reg), sem_pkg::MAX_HEIGHT);
        c = (col_pos >= LINE_DEPTH) ? LINE_DEPTH - 1 : col_pos;
        top_px = row_two_above[c];
        mid_px = row_above[c];
        bot_px = px;
        if (row_pos >= 2 && c >= 2 && row_pos < h && c < w)
        begin
            sx = (top_px + 2 * mid_px + bot_px) - (window[0] + 2 * window[2] + window[4]);
            sy = (window[4] + 2 * window[5] + bot_px) - (window[0] + 2 * window[1] + top_px);
            word.magnitude = floor_root(sx * sx + sy * sy);
            word.row = sem_pkg::ROW_W'(row_pos - 1);
            word.col = sem_pkg::COL_W'(c - 1);
            word.last = (row_pos == h - 1 && c == w - 1);
            gradient_queue.push_back(word);
        end
        row_two_above[c] = mid_px[sem_pkg::PIXEL_W-1:0];
        row_above[c] = px;
        window[0] = window[1];
        window[1] = top_px;
        window[2] = window[3];
        window[3] = mid_px;
        window[4] = window[5];
        window[5] = bot_px;
        if (col_pos + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end
        else
        begin
            col_pos++;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    task automatic write_register(input logic [sem_pkg::CFG_INDEX_W-1:0] index,
                                  input logic [sem_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        if (index == sem_pkg::CFG_FRAME_WIDTH)
        begin
            width_reg = value[sem_pkg::FRAME_W_W-1:0];
        end
        else
        begin
            height_reg = value;
        end
        col_pos = 0;
        row_pos = 0;
    endtask

    task automatic queue_pixels(input int count, input texture_t tex);
        for (int i = 0; i < count; i++)
        begin
            case (tex)
                TEX_BINARY: pixel_queue.push_back($urandom_range(1) ? 8'hFF : 8'h00);
                TEX_FLAT:   pixel_queue.push_back(8'(96 + $urandom_range(24)));
                default:    pixel_queue.push_back(8'($urandom_range(255)));
            endcase
        end
    endtask

    // A border pixel leaves no result, so the core may still be busy after the last word.
    task automatic drain_and_settle();
        while (pixel_queue.size() != 0 || pixel_valid || gradient_queue.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (!pixel_valid || pixel_taken_now)
        begin
            if (pixel_queue.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                pixel_valid <= 1'b1;
                pixel <= pixel_queue.pop_front();
            end
            else
            begin
                pixel_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (!hold_started && pixels_taken >= HOLD_AFTER)
        begin
            hold_started = 1'b1;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge clk)
    begin
        pixel_taken_now = pixel_valid && pixel_ready;
        if (pixel_taken_now)
        begin
            compute_gradient(pixel);
            pixels_taken++;
        end
        if (result_valid && result_ready)
        begin
            if (gradient_queue.size() == 0)
            begin
                $error("unexpected result word at row %0d, col %0d", out_row, out_col);
                failures++;
            end
            else
            begin
                head = gradient_queue.pop_front();
                check_field("magnitude", 32'(head.magnitude), 32'(magnitude));
                check_field("out_row", 32'(head.row), 32'(out_row));
                check_field("out_col", 32'(head.col), 32'(out_col));
                check_field("frame_last", 32'(head.last), 32'(frame_last));
            end
        end
    end

    initial
    begin
        int w;
        int h;
        int count;
        int random_total;
        texture_t tex;
        foreach (window[i])
        begin
            window[i] = 0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // At the reset size no interior pixel is reached this early.
        queue_pixels(20, TEX_RANDOM);
        drain_and_settle();

        write_register(sem_pkg::CFG_FRAME_WIDTH, 13'd3);
        write_register(sem_pkg::CFG_FRAME_HEIGHT, 13'd3);
        for (int i = 0; i < 9; i++)
        begin
            pixel_queue.push_back(((i / 3 + i % 3) % 2 == 1) ? 8'hFF : 8'h00);
        end
        drain_and_settle();

        // Sizes below three clamp to three; the upper data bits are not part of the width.
        write_register(sem_pkg::CFG_FRAME_WIDTH, 13'h1800);
        write_register(sem_pkg::CFG_FRAME_HEIGHT, 13'd2);
        for (int i = 0; i < 9; i++)
        begin
            pixel_queue.push_back((i % 3 == 0) ? 8'hFF : 8'h00);
        end
        for (int i = 0; i < 9; i++)
        begin
            pixel_queue.push_back(8'd128);
        end
        drain_and_settle();

        write_register(sem_pkg::CFG_FRAME_WIDTH, 13'd3);
        write_register(sem_pkg::CFG_FRAME_HEIGHT, 13'h1FFF);
        queue_pixels(45, TEX_RANDOM);
        drain_and_settle();

        write_register(sem_pkg::CFG_FRAME_WIDTH, 13'd1024);
        write_register(sem_pkg::CFG_FRAME_HEIGHT, 13'd4096);
        queue_pixels(30, TEX_BINARY);
        drain_and_settle();

        random_total = 0;
        while (random_total < RANDOM_PIXELS)
        begin
            w = ($urandom_range(7) == 0) ? $urandom_range(0, 40) : $urandom_range(3, 10);
            h = $urandom_range(0, 8);
            case ($urandom_range(3))
                0: write_register(sem_pkg::CFG_FRAME_WIDTH, w[sem_pkg::CFG_DATA_W-1:0]);
                1: write_register(sem_pkg::CFG_FRAME_HEIGHT, h[sem_pkg::CFG_DATA_W-1:0]);
                default:
                begin
                    write_register(sem_pkg::CFG_FRAME_WIDTH, w[sem_pkg::CFG_DATA_W-1:0]);
                    write_register(sem_pkg::CFG_FRAME_HEIGHT, h[sem_pkg::CFG_DATA_W-1:0]);
                end
            endcase
            count = clamp_size(int'(width_reg), LINE_DEPTH)
                    * clamp_size(int'(height_reg), sem_pkg::MAX_HEIGHT)
                    * $urandom_range(1, 2);
            if ($urandom_range(3) == 0)
            begin
                count = $urandom_range(1, count);
            end
            tex = texture_t'($urandom_range(2));
            queue_pixels(count, tex);
            random_total += count;
            drain_and_settle();
        end

        // One full frame sent without any idle cycles.
        idle_pct = 0;
        write_register(sem_pkg::CFG_FRAME_WIDTH, 13'd25);
        write_register(sem_pkg::CFG_FRAME_HEIGHT, 13'd6);
        queue_pixels(25 * 6, TEX_RANDOM);
        drain_and_settle();

        if (failures == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/sem_pkg.sv
hw/rtl/sobel_edge_magnitude_core.sv
test/sobel_edge_magnitude_core_test.sv
